>>> rtl/gcls_pkg.sv
// Shared types and constants for the greedy cut level scan unit.
`timescale 1ns / 1ps
`default_nettype none

package gcls_pkg;

	localparam int COORD_W    = 4;
	localparam int COORD_SPAN = 16;
	localparam int CFG_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int VAL_W      = 32;
	localparam int WEIGHT_W   = 31;
	localparam int GAIN_W     = 35;
	localparam int SUM_W      = 56;
	localparam int EPOCH_W    = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH  = 2'd2;

	// Pass tag stored per node; a node is visited when its tag equals the current pass tag
	typedef logic [EPOCH_W-1:0] tag_t;
	localparam tag_t EPOCH_MAX = '1;

	typedef enum logic {
		MAP_CLEAR,
		MAP_RUN
	} map_state_t;

	typedef struct packed {
		tag_t xm;
		tag_t xp;
		tag_t ym;
		tag_t yp;
		tag_t zm;
		tag_t zp;
	} nbr_tags_t;

	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} lw_t;

	typedef struct packed {
		logic               en;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		tag_t               tag;
	} wr_req_t;

endpackage

`default_nettype wire

>>> rtl/gcls_map.sv
// Visited map: four row banks split by y and z parity, two row reads each, with clear sweep.
`timescale 1ns / 1ps
`default_nettype none

module gcls_map #(
	parameter int MAP_W = 16,
	parameter int MAP_H = 16,
	parameter int MAP_D = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         rd_en,
	input  wire logic [gcls_pkg::COORD_W-1:0] rd_x,
	input  wire logic [gcls_pkg::COORD_W-1:0] rd_y,
	input  wire logic [gcls_pkg::COORD_W-1:0] rd_z,
	input  wire gcls_pkg::wr_req_t            wr,
	input  wire logic                         clear_start,
	output logic                              clear_busy,
	output gcls_pkg::nbr_tags_t               tags
);

	localparam int HB         = (MAP_H + 1) / 2;
	localparam int DB         = (MAP_D + 1) / 2;
	localparam int BANK_DEPTH = HB * DB;
	localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int XI_W       = (MAP_W > 1) ? $clog2(MAP_W) : 1;

	typedef gcls_pkg::tag_t [MAP_W-1:0] row_t;

	gcls_pkg::map_state_t state_q, state_d;
	logic [BA_W-1:0]      cnt_q, cnt_d;

	logic [4:0] y5, ym5, yp5, z5, zm5, zp5, x5;
	logic [gcls_pkg::COORD_W-1:0] rx_q;
	logic       ryp_q, rzp_q;
	logic [1:0] bank_c, bank_y, bank_z;

	row_t rd_a [4];
	row_t rd_b [4];

	function automatic logic [BA_W-1:0] row_addr(input logic [4:0] yy, input logic [4:0] zz);
		int a;
		a = 0;
		if (int'(yy) < MAP_H && int'(zz) < MAP_D)
			a = int'(zz >> 1) * HB + int'(yy >> 1);
		return BA_W'(a);
	endfunction

	function automatic gcls_pkg::tag_t pick(input row_t r, input logic [4:0] idx);
		if (int'(idx) < MAP_W)
			return r[idx[XI_W-1:0]];
		return '0;
	endfunction

	assign y5  = {1'b0, rd_y};
	assign z5  = {1'b0, rd_z};
	assign ym5 = y5 - 5'd1;
	assign yp5 = y5 + 5'd1;
	assign zm5 = z5 - 5'd1;
	assign zp5 = z5 + 5'd1;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic BY = 1'(b % 2);
		localparam logic BZ = 1'(b / 2);

		row_t            mem [BANK_DEPTH];
		row_t            rda_q, rdb_q;
		logic [BA_W-1:0] addr_a, addr_b, waddr;

		always_comb begin
			if (BZ == rd_z[0] && BY == rd_y[0]) begin
				addr_a = row_addr(y5, z5);
				addr_b = addr_a;
			end else if (BZ == rd_z[0]) begin
				addr_a = row_addr(ym5, z5);
				addr_b = row_addr(yp5, z5);
			end else if (BY == rd_y[0]) begin
				addr_a = row_addr(y5, zm5);
				addr_b = row_addr(y5, zp5);
			end else begin
				addr_a = '0;
				addr_b = '0;
			end
		end

		assign waddr = row_addr({1'b0, wr.y}, {1'b0, wr.z});

		always_ff @(posedge clk) begin
			if (rd_en) begin
				rda_q <= mem[addr_a];
				rdb_q <= mem[addr_b];
			end
		end

		always_ff @(posedge clk) begin
			if (state_q == gcls_pkg::MAP_CLEAR) begin
				mem[cnt_q] <= '0;
			end else if (wr.en && wr.y[0] == BY && wr.z[0] == BZ) begin
				mem[waddr][wr.x[XI_W-1:0]] <= wr.tag;
			end
		end

		assign rd_a[b] = rda_q;
		assign rd_b[b] = rdb_q;
	end

	// hold the read position for selecting tags out of the rows
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rx_q  <= rd_x;
			ryp_q <= rd_y[0];
			rzp_q <= rd_z[0];
		end
	end

	assign x5     = {1'b0, rx_q};
	assign bank_c = {rzp_q, ryp_q};
	assign bank_y = {rzp_q, ~ryp_q};
	assign bank_z = {~rzp_q, ryp_q};

	always_comb begin
		tags.xm = pick(rd_a[bank_c], x5 - 5'd1);
		tags.xp = pick(rd_a[bank_c], x5 + 5'd1);
		tags.ym = pick(rd_a[bank_y], x5);
		tags.yp = pick(rd_b[bank_y], x5);
		tags.zm = pick(rd_a[bank_z], x5);
		tags.zp = pick(rd_b[bank_z], x5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcls_pkg::MAP_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		clear_busy = 1'b0;
		case (state_q)
			gcls_pkg::MAP_CLEAR: begin
				clear_busy = 1'b1;
				if (cnt_q == BA_W'(BANK_DEPTH - 1)) begin
					state_d = gcls_pkg::MAP_RUN;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + BA_W'(1);
				end
			end
			gcls_pkg::MAP_RUN: begin
				if (clear_start) begin
					state_d = gcls_pkg::MAP_CLEAR;
					cnt_d   = '0;
				end
			end
			default: begin
				state_d = gcls_pkg::MAP_CLEAR;
				cnt_d   = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/gcls_gain.sv
// Node gain: unary cost and signed edge terms from neighbor visited state.
`timescale 1ns / 1ps
`default_nettype none

module gcls_gain #(
	parameter int MAP_W = 16,
	parameter int MAP_H = 16,
	parameter int MAP_D = 16
) (
	input  wire logic [gcls_pkg::COORD_W-1:0]     x,
	input  wire logic [gcls_pkg::COORD_W-1:0]     y,
	input  wire logic [gcls_pkg::COORD_W-1:0]     z,
	input  wire logic signed [gcls_pkg::VAL_W-1:0] unary,
	input  wire logic [gcls_pkg::WEIGHT_W-1:0]    w_xm,
	input  wire logic [gcls_pkg::WEIGHT_W-1:0]    w_xp,
	input  wire logic [gcls_pkg::WEIGHT_W-1:0]    w_ym,
	input  wire logic [gcls_pkg::WEIGHT_W-1:0]    w_yp,
	input  wire logic [gcls_pkg::WEIGHT_W-1:0]    w_zm,
	input  wire logic [gcls_pkg::WEIGHT_W-1:0]    w_zp,
	input  wire logic                             first,
	input  wire gcls_pkg::tag_t                   epoch,
	input  wire gcls_pkg::nbr_tags_t              tags,
	input  wire gcls_pkg::lw_t                    lw,
	input  wire logic [gcls_pkg::CFG_W-1:0]       w_eff,
	input  wire logic [gcls_pkg::CFG_W-1:0]       h_eff,
	input  wire logic [gcls_pkg::CFG_W-1:0]       d_eff,
	output logic signed [gcls_pkg::GAIN_W-1:0]    gain,
	output logic                                  in_grid
);

	localparam int GW = gcls_pkg::GAIN_W;

	logic [4:0] x5, y5, z5;
	logic on_xm, on_xp, on_ym, on_yp, on_zm, on_zp;
	logic vis_xm, vis_xp, vis_ym, vis_yp, vis_zm, vis_zp;

	function automatic logic signed [GW-1:0] term(
		input logic                          on,
		input logic                          vis,
		input logic [gcls_pkg::WEIGHT_W-1:0] w
	);
		logic signed [GW-1:0] ws;
		ws = signed'(GW'(w));
		if (!on)
			return '0;
		return vis ? -ws : ws;
	endfunction

	assign x5 = {1'b0, x};
	assign y5 = {1'b0, y};
	assign z5 = {1'b0, z};

	always_comb begin
		in_grid = (x5 < w_eff) && (y5 < h_eff) && (z5 < d_eff);

		on_xm = (x != '0);
		on_xp = ((x5 + 5'd1) < w_eff);
		on_ym = (y != '0);
		on_yp = ((y5 + 5'd1) < h_eff);
		on_zm = (z != '0);
		on_zp = ((z5 + 5'd1) < d_eff);

		// a neighbor past the stored span is never visited; the last write is
		// not yet in the map when this item read it, so check it directly
		vis_xm = !first && ((tags.xm == epoch) ||
			(lw.valid && lw.x == x - 4'd1 && lw.y == y && lw.z == z));
		vis_xp = !first && (int'(x5 + 5'd1) < MAP_W) && ((tags.xp == epoch) ||
			(lw.valid && lw.x == x + 4'd1 && lw.y == y && lw.z == z));
		vis_ym = !first && ((tags.ym == epoch) ||
			(lw.valid && lw.x == x && lw.y == y - 4'd1 && lw.z == z));
		vis_yp = !first && (int'(y5 + 5'd1) < MAP_H) && ((tags.yp == epoch) ||
			(lw.valid && lw.x == x && lw.y == y + 4'd1 && lw.z == z));
		vis_zm = !first && ((tags.zm == epoch) ||
			(lw.valid && lw.x == x && lw.y == y && lw.z == z - 4'd1));
		vis_zp = !first && (int'(z5 + 5'd1) < MAP_D) && ((tags.zp == epoch) ||
			(lw.valid && lw.x == x && lw.y == y && lw.z == z + 4'd1));

		gain = -(GW'(unary))
			+ term(on_xm, vis_xm, w_xm) + term(on_xp, vis_xp, w_xp)
			+ term(on_ym, vis_ym, w_ym) + term(on_yp, vis_yp, w_yp)
			+ term(on_zm, vis_zm, w_zm) + term(on_zp, vis_zp, w_zp);
	end

endmodule

`default_nettype wire

>>> rtl/gcls_acc.sv
// Saturating running sum, pass minimum and best level registers.
`timescale 1ns / 1ps
`default_nettype none

module gcls_acc (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              adv,
	input  wire logic signed [gcls_pkg::GAIN_W-1:0] gain,
	input  wire logic signed [gcls_pkg::VAL_W-1:0]  level,
	input  wire logic                              first,
	input  wire logic                              in_grid,
	output logic signed [gcls_pkg::SUM_W-1:0]      sum_q,
	output logic signed [gcls_pkg::SUM_W-1:0]      min_q,
	output logic signed [gcls_pkg::VAL_W-1:0]      best_q,
	output logic                                   improved_q
);

	localparam int SW = gcls_pkg::SUM_W;
	localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW - 1){1'b1}}};
	localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW - 1){1'b0}}};

	logic signed [SW-1:0]           sum_base, min_base, sat, sum_d, min_d;
	logic signed [SW:0]             sum_ext;
	logic signed [gcls_pkg::VAL_W-1:0] best_base, best_d;
	logic                           imp_d;

	always_comb begin
		sum_base  = first ? '0 : sum_q;
		min_base  = first ? SUM_MAX : min_q;
		best_base = first ? '0 : best_q;

		sum_ext = (SW + 1)'(sum_base) + (SW + 1)'(gain);
		if (sum_ext[SW] != sum_ext[SW-1])
			sat = sum_ext[SW] ? SUM_MIN : SUM_MAX;
		else
			sat = sum_ext[SW-1:0];

		sum_d  = sum_base;
		min_d  = min_base;
		best_d = best_base;
		imp_d  = 1'b0;
		if (in_grid) begin
			sum_d = sat;
			if (sat < min_base) begin
				min_d  = sat;
				best_d = level;
				imp_d  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			min_q      <= SUM_MAX;
			best_q     <= '0;
			improved_q <= 1'b0;
		end else if (adv) begin
			sum_q      <= sum_d;
			min_q      <= min_d;
			best_q     <= best_d;
			improved_q <= imp_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/greedy_cut_level_scan_unit.sv
// Top level of the greedy cut level scan unit.
//
// Input channel (in_valid/in_ready) takes one grid node per transfer, already
// sorted by level. Output channel (out_valid/out_ready) returns one result per
// node: running sum, pass minimum, best level and an improved flag.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes grid_width,
// grid_height and grid_depth by index; write it only while the unit is idle.
// A node passes through the stage 1, stage 2 and result registers. One node is
// accepted every cycle unless a stall or clear sweep holds the flow: the
// visited-map read registers with the node, the six-neighbor gain is formed
// in the next stage and the accumulator closes the sum in the result register.
// After reset the visited map is swept clear, one row per cycle, covering
// ceil(MAP_H/2)*ceil(MAP_D/2) rows per bank (64 at the defaults) while
// in_ready stays low. Passes are told apart by a 4-bit tag, so every 15th
// first-flagged node causes the same sweep before it goes through.
// When out_ready is low the result holds and the two inner stages fill, after
// which in_ready drops until the output drains.
`timescale 1ns / 1ps
`default_nettype none

module greedy_cut_level_scan_unit #(
	parameter int MAX_WIDTH  = 16,
	parameter int MAX_HEIGHT = 16,
	parameter int MAX_DEPTH  = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [gcls_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [gcls_pkg::CFG_W-1:0]            cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [gcls_pkg::COORD_W-1:0]          pos_x,
	input  wire logic [gcls_pkg::COORD_W-1:0]          pos_y,
	input  wire logic [gcls_pkg::COORD_W-1:0]          pos_z,
	input  wire logic signed [gcls_pkg::VAL_W-1:0]     level,
	input  wire logic signed [gcls_pkg::VAL_W-1:0]     unary,
	input  wire logic [gcls_pkg::WEIGHT_W-1:0]         weight_x_minus,
	input  wire logic [gcls_pkg::WEIGHT_W-1:0]         weight_x_plus,
	input  wire logic [gcls_pkg::WEIGHT_W-1:0]         weight_y_minus,
	input  wire logic [gcls_pkg::WEIGHT_W-1:0]         weight_y_plus,
	input  wire logic [gcls_pkg::WEIGHT_W-1:0]         weight_z_minus,
	input  wire logic [gcls_pkg::WEIGHT_W-1:0]         weight_z_plus,
	input  wire logic                                  first,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [gcls_pkg::SUM_W-1:0]          running_sum,
	output logic signed [gcls_pkg::SUM_W-1:0]          minimum_sum,
	output logic signed [gcls_pkg::VAL_W-1:0]          best_level,
	output logic                                       improved
);

	localparam int MAP_W = (MAX_WIDTH < gcls_pkg::COORD_SPAN) ? MAX_WIDTH : gcls_pkg::COORD_SPAN;
	localparam int MAP_H = (MAX_HEIGHT < gcls_pkg::COORD_SPAN) ? MAX_HEIGHT : gcls_pkg::COORD_SPAN;
	localparam int MAP_D = (MAX_DEPTH < gcls_pkg::COORD_SPAN) ? MAX_DEPTH : gcls_pkg::COORD_SPAN;

	function automatic logic [gcls_pkg::CFG_W-1:0] eff_dim(
		input logic [gcls_pkg::CFG_W-1:0] r,
		input int                         mx
	);
		if (r == '0)
			return gcls_pkg::CFG_W'(1);
		if (int'(r) > mx)
			return gcls_pkg::CFG_W'(mx);
		return r;
	endfunction

	// configuration
	logic [gcls_pkg::CFG_W-1:0] grid_width_q, grid_height_q, grid_depth_q;
	logic [gcls_pkg::CFG_W-1:0] w_eff, h_eff, d_eff;

	// stage 1: node fields, map rows read at acceptance
	logic                               valid_s1;
	logic [gcls_pkg::COORD_W-1:0]       x_s1, y_s1, z_s1;
	logic signed [gcls_pkg::VAL_W-1:0]  level_s1, unary_s1;
	logic [gcls_pkg::WEIGHT_W-1:0]      wxm_s1, wxp_s1, wym_s1, wyp_s1, wzm_s1, wzp_s1;
	logic                               first_s1;

	// stage 2: gain
	logic                               valid_s2;
	logic signed [gcls_pkg::GAIN_W-1:0] gain_s2;
	logic signed [gcls_pkg::VAL_W-1:0]  level_s2;
	logic                               first_s2;
	logic                               hit_s2;

	logic                               out_valid_q;

	gcls_pkg::tag_t      epoch_q;
	gcls_pkg::lw_t       lw_q;
	gcls_pkg::wr_req_t   wr;
	gcls_pkg::nbr_tags_t tags;

	logic signed [gcls_pkg::GAIN_W-1:0] gain_c;
	logic in_grid_c;
	logic clear_busy, need_clear, clear_start;
	logic out_free, adv_s2, s2_free, adv_s1, in_fire;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= gcls_pkg::CFG_W'(16);
			grid_height_q <= gcls_pkg::CFG_W'(16);
			grid_depth_q  <= gcls_pkg::CFG_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gcls_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				gcls_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				gcls_pkg::REG_GRID_DEPTH:  grid_depth_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_eff = eff_dim(grid_width_q, MAX_WIDTH);
	assign h_eff = eff_dim(grid_height_q, MAX_HEIGHT);
	assign d_eff = eff_dim(grid_depth_q, MAX_DEPTH);

	// flow control
	assign out_free    = !out_valid_q || out_ready;
	assign adv_s2      = valid_s2 && out_free;
	assign s2_free     = !valid_s2 || adv_s2;
	assign need_clear  = valid_s1 && first_s1 && (epoch_q == gcls_pkg::EPOCH_MAX);
	assign clear_start = need_clear && !clear_busy;
	assign adv_s1      = valid_s1 && s2_free && !clear_busy && !need_clear;
	assign in_ready    = !clear_busy && (!valid_s1 || adv_s1);
	assign in_fire     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				valid_s2 <= 1'b1;
			else if (adv_s2)
				valid_s2 <= 1'b0;
			if (adv_s2)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_s1     <= pos_x;
			y_s1     <= pos_y;
			z_s1     <= pos_z;
			level_s1 <= level;
			unary_s1 <= unary;
			wxm_s1   <= weight_x_minus;
			wxp_s1   <= weight_x_plus;
			wym_s1   <= weight_y_minus;
			wyp_s1   <= weight_y_plus;
			wzm_s1   <= weight_z_minus;
			wzp_s1   <= weight_z_plus;
			first_s1 <= first;
		end
		if (adv_s1) begin
			gain_s2  <= gain_c;
			level_s2 <= level_s1;
			first_s2 <= first_s1;
			hit_s2   <= in_grid_c;
		end
	end

	// pass tag and the write that the next node cannot see in its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q <= gcls_pkg::tag_t'(1);
			lw_q    <= '0;
		end else begin
			if (clear_start)
				epoch_q <= '0;
			else if (adv_s1 && first_s1)
				epoch_q <= epoch_q + gcls_pkg::tag_t'(1);
			if (adv_s1) begin
				if (in_grid_c) begin
					lw_q.valid <= 1'b1;
					lw_q.x     <= x_s1;
					lw_q.y     <= y_s1;
					lw_q.z     <= z_s1;
				end else if (first_s1) begin
					lw_q.valid <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		wr.en  = adv_s1 && in_grid_c;
		wr.x   = x_s1;
		wr.y   = y_s1;
		wr.z   = z_s1;
		wr.tag = first_s1 ? epoch_q + gcls_pkg::tag_t'(1) : epoch_q;
	end

	gcls_map #(
		.MAP_W(MAP_W),
		.MAP_H(MAP_H),
		.MAP_D(MAP_D)
	) u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (in_fire),
		.rd_x       (pos_x),
		.rd_y       (pos_y),
		.rd_z       (pos_z),
		.wr         (wr),
		.clear_start(clear_start),
		.clear_busy (clear_busy),
		.tags       (tags)
	);

	gcls_gain #(
		.MAP_W(MAP_W),
		.MAP_H(MAP_H),
		.MAP_D(MAP_D)
	) u_gain (
		.x      (x_s1),
		.y      (y_s1),
		.z      (z_s1),
		.unary  (unary_s1),
		.w_xm   (wxm_s1),
		.w_xp   (wxp_s1),
		.w_ym   (wym_s1),
		.w_yp   (wyp_s1),
		.w_zm   (wzm_s1),
		.w_zp   (wzp_s1),
		.first  (first_s1),
		.epoch  (epoch_q),
		.tags   (tags),
		.lw     (lw_q),
		.w_eff  (w_eff),
		.h_eff  (h_eff),
		.d_eff  (d_eff),
		.gain   (gain_c),
		.in_grid(in_grid_c)
	);

	gcls_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv_s2),
		.gain      (gain_s2),
		.level     (level_s2),
		.first     (first_s2),
		.in_grid   (hit_s2),
		.sum_q     (running_sum),
		.min_q     (minimum_sum),
		.best_q    (best_level),
		.improved_q(improved)
	);

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> test/tb_greedy_cut_level_scan_unit.sv
// Testbench for the greedy cut level scan unit: random and directed nodes checked against a predictor.
`timescale 1ns / 1ps

module tb_greedy_cut_level_scan_unit;

	localparam int MAX_W = 16;
	localparam int MAX_H = 16;
	localparam int MAX_D = 16;
	localparam int MAP_NODES = MAX_W * MAX_H * MAX_D;
	localparam longint SUM_TOP = 64'sh007F_FFFF_FFFF_FFFF;
	localparam longint SUM_BOTTOM = -SUM_TOP - 1;
	localparam logic [gcls_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [gcls_pkg::WEIGHT_W-1:0] WEIGHT_TOP = '1;
	localparam logic signed [gcls_pkg::VAL_W-1:0] VAL_TOP = 32'sh7FFF_FFFF;
	localparam logic signed [gcls_pkg::VAL_W-1:0] VAL_BOTTOM = 32'sh8000_0000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 50000;

	typedef struct packed {
		logic [gcls_pkg::COORD_W-1:0]      pos_x;
		logic [gcls_pkg::COORD_W-1:0]      pos_y;
		logic [gcls_pkg::COORD_W-1:0]      pos_z;
		logic signed [gcls_pkg::VAL_W-1:0] level;
		logic signed [gcls_pkg::VAL_W-1:0] unary;
		logic [gcls_pkg::WEIGHT_W-1:0]     w_xm;
		logic [gcls_pkg::WEIGHT_W-1:0]     w_xp;
		logic [gcls_pkg::WEIGHT_W-1:0]     w_ym;
		logic [gcls_pkg::WEIGHT_W-1:0]     w_yp;
		logic [gcls_pkg::WEIGHT_W-1:0]     w_zm;
		logic [gcls_pkg::WEIGHT_W-1:0]     w_zp;
		logic                              first;
	} node_t;

	typedef struct packed {
		logic signed [gcls_pkg::SUM_W-1:0] running_sum;
		logic signed [gcls_pkg::SUM_W-1:0] minimum_sum;
		logic signed [gcls_pkg::VAL_W-1:0] best_level;
		logic                              improved;
	} scan_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [gcls_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [gcls_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	node_t drv_node = '0;

	wire cfg_ready;
	wire in_ready;
	wire out_valid;
	wire signed [gcls_pkg::SUM_W-1:0] running_sum;
	wire signed [gcls_pkg::SUM_W-1:0] minimum_sum;
	wire signed [gcls_pkg::VAL_W-1:0] best_level;
	wire improved;

	node_t nodes_to_send[$];
	scan_result_t scan_results_due[$];
	scan_result_t oldest;

	// predictor state
	logic [gcls_pkg::CFG_W-1:0] grid_w_cfg, grid_h_cfg, grid_d_cfg;
	bit node_seen[MAP_NODES];
	longint scan_sum, scan_min;
	logic signed [gcls_pkg::VAL_W-1:0] scan_best;

	int fail_count = 0;
	int results_seen = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	logic in_xfer = 1'b0;

	greedy_cut_level_scan_unit #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H),
		.MAX_DEPTH(MAX_D)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pos_x(drv_node.pos_x),
		.pos_y(drv_node.pos_y),
		.pos_z(drv_node.pos_z),
		.level(drv_node.level),
		.unary(drv_node.unary),
		.weight_x_minus(drv_node.w_xm),
		.weight_x_plus(drv_node.w_xp),
		.weight_y_minus(drv_node.w_ym),
		.weight_y_plus(drv_node.w_yp),
		.weight_z_minus(drv_node.w_zm),
		.weight_z_plus(drv_node.w_zp),
		.first(drv_node.first),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.running_sum(running_sum),
		.minimum_sum(minimum_sum),
		.best_level(best_level),
		.improved(improved)
	);

	always #1 clk = ~clk;

	function automatic int unsigned eff_dim(logic [gcls_pkg::CFG_W-1:0] r, int unsigned lim);
		if (r == 0)
			return 1;
		return (int'(r) > lim) ? lim : int'(r);
	endfunction

	function automatic int unsigned node_addr(int unsigned x, int unsigned y, int unsigned z);
		return (z * MAX_H + y) * MAX_W + x;
	endfunction

	function automatic void clear_pass();
		foreach (node_seen[i])
			node_seen[i] = 1'b0;
		scan_sum = 0;
		scan_min = SUM_TOP;
		scan_best = '0;
	endfunction

	// append a node to the tail of the send queue
	function automatic void add_node(node_t n);
		nodes_to_send.insert(nodes_to_send.size(), n);
	endfunction

	// an unvisited neighbor adds the edge weight, a visited one takes it away
	function automatic longint edge_term(int unsigned x, int unsigned y, int unsigned z,
			logic [gcls_pkg::WEIGHT_W-1:0] wt);
		longint v;
		v = longint'({1'b0, wt});
		return node_seen[node_addr(x, y, z)] ? -v : v;
	endfunction

	function automatic scan_result_t predict_scan(node_t n);
		int unsigned w, h, d, x, y, z;
		longint gain, s;
		scan_result_t r;
		w = eff_dim(grid_w_cfg, MAX_W);
		h = eff_dim(grid_h_cfg, MAX_H);
		d = eff_dim(grid_d_cfg, MAX_D);
		x = 32'(n.pos_x);
		y = 32'(n.pos_y);
		z = 32'(n.pos_z);
		r.improved = 1'b0;
		if (n.first)
			clear_pass();
		if (x < w && y < h && z < d) begin
			gain = -longint'($signed(n.unary));
			if (x > 0)
				gain += edge_term(x - 1, y, z, n.w_xm);
			if (x + 1 < w)
				gain += edge_term(x + 1, y, z, n.w_xp);
			if (y > 0)
				gain += edge_term(x, y - 1, z, n.w_ym);
			if (y + 1 < h)
				gain += edge_term(x, y + 1, z, n.w_yp);
			if (z > 0)
				gain += edge_term(x, y, z - 1, n.w_zm);
			if (z + 1 < d)
				gain += edge_term(x, y, z + 1, n.w_zp);
			node_seen[node_addr(x, y, z)] = 1'b1;
			s = scan_sum + gain;
			if (s > SUM_TOP)
				s = SUM_TOP;
			if (s < SUM_BOTTOM)
				s = SUM_BOTTOM;
			scan_sum = s;
			if (s < scan_min) begin
				scan_min = s;
				scan_best = n.level;
				r.improved = 1'b1;
			end
		end
		r.running_sum = scan_sum[gcls_pkg::SUM_W-1:0];
		r.minimum_sum = scan_min[gcls_pkg::SUM_W-1:0];
		r.best_level = scan_best;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic logic [gcls_pkg::WEIGHT_W-1:0] rand_weight();
		case ($urandom_range(9))
			0: return '0;
			1: return WEIGHT_TOP;
			2, 3, 4, 5: return gcls_pkg::WEIGHT_W'($urandom_range(0, 32'h0004_0000));
			default: return gcls_pkg::WEIGHT_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [gcls_pkg::VAL_W-1:0] rand_value();
		case ($urandom_range(9))
			0: return VAL_BOTTOM;
			1: return VAL_TOP;
			2, 3, 4, 5: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic node_t mk_node(int unsigned x, int unsigned y, int unsigned z,
			logic signed [gcls_pkg::VAL_W-1:0] lvl, logic signed [gcls_pkg::VAL_W-1:0] un,
			logic [gcls_pkg::WEIGHT_W-1:0] wt, logic fst);
		node_t n;
		n.pos_x = gcls_pkg::COORD_W'(x);
		n.pos_y = gcls_pkg::COORD_W'(y);
		n.pos_z = gcls_pkg::COORD_W'(z);
		n.level = lvl;
		n.unary = un;
		n.w_xm = wt;
		n.w_xp = wt;
		n.w_ym = wt;
		n.w_yp = wt;
		n.w_zm = wt;
		n.w_zp = wt;
		n.first = fst;
		return n;
	endfunction

	// passes open with a first node; most nodes land inside the active grid
	task automatic queue_passes(int unsigned count);
		int unsigned w, h, d, queued, len;
		bit in_grid;
		node_t n;
		w = eff_dim(grid_w_cfg, MAX_W);
		h = eff_dim(grid_h_cfg, MAX_H);
		d = eff_dim(grid_d_cfg, MAX_D);
		queued = 0;
		while (queued < count) begin
			len = $urandom_range(1, 40);
			for (int i = 0; i < len && queued < count; i++) begin
				in_grid = ($urandom_range(9) != 0);
				n.pos_x = gcls_pkg::COORD_W'(in_grid ? $urandom_range(0, w - 1)
					: $urandom_range(0, 15));
				n.pos_y = gcls_pkg::COORD_W'(in_grid ? $urandom_range(0, h - 1)
					: $urandom_range(0, 15));
				n.pos_z = gcls_pkg::COORD_W'(in_grid ? $urandom_range(0, d - 1)
					: $urandom_range(0, 15));
				n.level = $urandom;
				n.unary = rand_value();
				n.w_xm = rand_weight();
				n.w_xp = rand_weight();
				n.w_ym = rand_weight();
				n.w_yp = rand_weight();
				n.w_zm = rand_weight();
				n.w_zp = rand_weight();
				n.first = (i == 0);
				add_node(n);
				queued++;
			end
		end
	endtask

	task automatic write_cfg(logic [gcls_pkg::CFG_IDX_W-1:0] idx, logic [gcls_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_grid(logic [gcls_pkg::CFG_W-1:0] w, logic [gcls_pkg::CFG_W-1:0] h,
			logic [gcls_pkg::CFG_W-1:0] d);
		write_cfg(gcls_pkg::REG_GRID_WIDTH, w);
		write_cfg(gcls_pkg::REG_GRID_HEIGHT, h);
		write_cfg(gcls_pkg::REG_GRID_DEPTH, d);
	endtask

	// wait until every node is sent and answered, then let the pipeline settle
	task automatic wait_idle();
		int waited;
		waited = 0;
		while ((nodes_to_send.size() != 0 || in_valid || scan_results_due.size() != 0)
				&& waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (nodes_to_send.size() != 0 || in_valid) begin
			report_mismatch($sformatf("%0d nodes never taken", nodes_to_send.size()));
			nodes_to_send.delete();
		end
		if (scan_results_due.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", scan_results_due.size()));
			scan_results_due.delete();
		end
		repeat (8) @(posedge clk);
	endtask

	// sender: hold the payload until the transfer happens
	always @(negedge clk) begin
		if (!in_valid || in_xfer) begin
			if (nodes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_node <= nodes_to_send.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		in_xfer <= in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gcls_pkg::REG_GRID_WIDTH: grid_w_cfg <= cfg_data;
					gcls_pkg::REG_GRID_HEIGHT: grid_h_cfg <= cfg_data;
					gcls_pkg::REG_GRID_DEPTH: grid_d_cfg <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				scan_results_due.insert(scan_results_due.size(), predict_scan(drv_node));
			if (out_valid && out_ready) begin
				if (scan_results_due.size() == 0) begin
					report_mismatch($sformatf("result %0d with nothing expected", results_seen));
				end else begin
					oldest = scan_results_due.pop_front();
					if (running_sum !== oldest.running_sum)
						report_mismatch($sformatf("result %0d running_sum %0d, expected %0d",
							results_seen, running_sum, oldest.running_sum));
					if (minimum_sum !== oldest.minimum_sum)
						report_mismatch($sformatf("result %0d minimum_sum %0d, expected %0d",
							results_seen, minimum_sum, oldest.minimum_sum));
					if (best_level !== oldest.best_level)
						report_mismatch($sformatf("result %0d best_level %0d, expected %0d",
							results_seen, best_level, oldest.best_level));
					if (improved !== oldest.improved)
						report_mismatch($sformatf("result %0d improved %0b, expected %0b",
							results_seen, improved, oldest.improved));
				end
				results_seen++;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		node_t n;
		int idle_tab[4];
		int stall_tab[4];
		int grid_tab[8][3];
		int k;
		idle_tab = '{0, 60, 0, 25};
		stall_tab = '{0, 0, 60, 25};
		grid_tab = '{'{16, 16, 16}, '{1, 1, 1}, '{2, 2, 2}, '{4, 3, 5},
			'{31, 0, 16}, '{16, 1, 8}, '{3, 16, 1}, '{0, 0, 0}};
		grid_w_cfg = 5'd16;
		grid_h_cfg = 5'd16;
		grid_d_cfg = 5'd16;
		clear_pass();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: full grid, corners, a visited neighbor, a revisit
		add_node(mk_node(0, 0, 0, VAL_BOTTOM, VAL_BOTTOM, WEIGHT_TOP, 1'b1));
		add_node(mk_node(15, 15, 15, VAL_TOP, VAL_TOP, WEIGHT_TOP, 1'b0));
		n = mk_node(1, 0, 0, 32'sd7, 32'sd0, '0, 1'b0);
		n.w_xm = WEIGHT_TOP;
		add_node(n);
		n = mk_node(0, 0, 0, 32'sd8, 32'sd0, '0, 1'b0);
		n.w_xp = 31'd5;
		add_node(n);
		add_node(mk_node(14, 15, 15, 32'sd9, VAL_TOP, '0, 1'b0));
		wait_idle();

		// directed: registers out of range, node off the grid, equal sum
		set_grid(5'd0, 5'd31, 5'd17);
		write_cfg(REG_UNUSED, 5'd31);
		add_node(mk_node(3, 0, 0, 32'sd1, 32'sd0, '0, 1'b1));
		add_node(mk_node(0, 0, 0, 32'sd2, 32'sd5, '0, 1'b0));
		add_node(mk_node(0, 1, 0, 32'sd3, 32'sd0, '0, 1'b0));
		add_node(mk_node(0, 0, 0, 32'sd4, 32'sd0, WEIGHT_TOP, 1'b0));
		add_node(mk_node(0, 0, 5, 32'sd5, 32'sd1, '0, 1'b0));
		add_node(mk_node(0, 15, 15, 32'sd6, VAL_BOTTOM, WEIGHT_TOP, 1'b0));
		add_node(mk_node(0, 0, 0, VAL_TOP, -32'sd1, '0, 1'b1));
		add_node(mk_node(15, 0, 0, 32'sd7, VAL_BOTTOM, '0, 1'b0));
		wait_idle();

		grid_tab[7] = '{$urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31)};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_tab[ph];
			stall_pct = stall_tab[ph];
			for (int seg = 0; seg < 2; seg++) begin
				k = ph * 2 + seg;
				set_grid(gcls_pkg::CFG_W'(grid_tab[k][0]), gcls_pkg::CFG_W'(grid_tab[k][1]),
					gcls_pkg::CFG_W'(grid_tab[k][2]));
				queue_passes(150);
				// stall the output for a long stretch so the unit backs up
				if (k == 0)
					hold_req++;
				wait_idle();
			end
		end

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
